### design/qftv_pkg.sv
// Shared widths, constants and helpers for the shortest-arc quaternion pipeline.
`timescale 1ns / 1ps
package qftv_pkg;

    localparam int NCOMP       = 4;
    localparam int COMP_W      = 64;
    localparam int MAG_W       = 63;
    localparam int NRM_W       = 31;
    localparam int SQ_W        = 62;
    localparam int SUM_W       = 63;
    localparam int ROOT_W      = 32;
    localparam int ROOT_STAGES = 32;
    localparam int NUM_W       = 61;
    localparam int QUO_W       = 31;
    localparam int DIV_STAGES  = QUO_W;
    localparam int BLEN_W      = 7;
    localparam int OUT_W       = 32;

    localparam int UNIT_SIDE_W = NCOMP * NRM_W + NCOMP + 1;
    localparam int DIV_SIDE_W  = NCOMP + 1;

    // Register counts through one normalizer and through the rotation core.
    localparam int UNIT_LAT  = 7 + ROOT_STAGES + DIV_STAGES + 1;
    localparam int CORE_LAT  = 3;
    localparam int TOTAL_LAT = 2 * UNIT_LAT + CORE_LAT;

    localparam logic [MAG_W-1:0] ONE_Q30_MAG = 63'd1073741824;
    localparam logic [QUO_W-1:0] ONE_Q30_QUO = 31'd1073741824;
    localparam logic signed [COMP_W-1:0] ONE_Q30      = 64'sd1073741824;
    localparam logic signed [COMP_W-1:0] HALF_Q30     = 64'sd536870912;
    localparam logic signed [COMP_W-1:0] DOT_OPPOSITE = -64'sd1073634449;
    localparam logic [OUT_W-1:0] Y_HINT_LIMIT = 32'd966367642;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [OUT_W-1:0]  t_unit;

    // Position of the highest set bit plus one; zero for a zero byte.
    function automatic logic [3:0] f_bitlen8(input logic [7:0] v);
        logic [3:0] bl;
        bl = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                bl = 4'(i + 1);
            end
        end
        return bl;
    endfunction

endpackage

### design/qftv_isqrt.sv
// Fully pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module qftv_isqrt
    import qftv_pkg::*;
#(
    parameter int SIDE_W = UNIT_SIDE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RES_W = SUM_W + 1;

    logic [SUM_W-1:0]  r_rem  [ROOT_STAGES];
    logic [RES_W-1:0]  r_res  [ROOT_STAGES];
    logic [SIDE_W-1:0] r_side [ROOT_STAGES];
    logic              r_vld  [ROOT_STAGES];

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (ROOT_STAGES - 1 - k));
        logic [SUM_W-1:0]  w_rem_in;
        logic [SUM_W-1:0]  n_rem;
        logic [RES_W-1:0]  w_res_in;
        logic [RES_W-1:0]  n_res;
        logic [RES_W-1:0]  w_trial;
        logic [SIDE_W-1:0] w_side_in;
        logic              w_vld_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_sum;
            assign w_res_in  = '0;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_res_in  = r_res[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        always_comb begin
            w_trial = w_res_in + BIT;
            if ({1'b0, w_rem_in} >= w_trial) begin
                n_rem = w_rem_in - w_trial[SUM_W-1:0];
                n_res = (w_res_in >> 1) + BIT;
            end else begin
                n_rem = w_rem_in;
                n_res = w_res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_res[k]  <= n_res;
            r_side[k] <= w_side_in;
        end
    end

    assign o_valid = r_vld[ROOT_STAGES-1];
    assign o_root  = r_res[ROOT_STAGES-1][ROOT_W-1:0];
    assign o_side  = r_side[ROOT_STAGES-1];

endmodule

### design/qftv_divider.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
`timescale 1ns / 1ps
module qftv_divider
    import qftv_pkg::*;
#(
    parameter int SIDE_W = DIV_SIDE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num [NCOMP],
    input  logic [ROOT_W-1:0] i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo [NCOMP],
    output logic [SIDE_W-1:0] o_side
);

    logic [ROOT_W-1:0] r_rem  [DIV_STAGES][NCOMP];
    logic [QUO_W-1:0]  r_quo  [DIV_STAGES][NCOMP];
    logic [QUO_W-1:0]  r_lo   [DIV_STAGES][NCOMP];
    logic [ROOT_W-1:0] r_den  [DIV_STAGES];
    logic [SIDE_W-1:0] r_side [DIV_STAGES];
    logic              r_vld  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [ROOT_W-1:0] w_rem_in [NCOMP];
        logic [QUO_W-1:0]  w_quo_in [NCOMP];
        logic [QUO_W-1:0]  w_lo_in  [NCOMP];
        logic [ROOT_W-1:0] w_den_in;
        logic [SIDE_W-1:0] w_side_in;
        logic              w_vld_in;
        logic [ROOT_W:0]   w_trial  [NCOMP];
        logic [ROOT_W-1:0] n_rem    [NCOMP];
        logic [QUO_W-1:0]  n_quo    [NCOMP];

        if (k == 0) begin : g_first
            for (genvar j = 0; j < NCOMP; j++) begin : g_lane
                // The quotient fits in QUO_W bits, so the upper numerator bits
                // are already a valid partial remainder.
                assign w_rem_in[j] = ROOT_W'(i_num[j][NUM_W-1:QUO_W]);
                assign w_quo_in[j] = '0;
                assign w_lo_in[j]  = i_num[j][QUO_W-1:0];
            end
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            for (genvar j = 0; j < NCOMP; j++) begin : g_lane
                assign w_rem_in[j] = r_rem[k-1][j];
                assign w_quo_in[j] = r_quo[k-1][j];
                assign w_lo_in[j]  = r_lo[k-1][j];
            end
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        always_comb begin
            for (int j = 0; j < NCOMP; j++) begin
                w_trial[j] = {w_rem_in[j], w_lo_in[j][QUO_W-1-k]};
                if (w_trial[j] >= {1'b0, w_den_in}) begin
                    n_rem[j] = ROOT_W'(w_trial[j] - {1'b0, w_den_in});
                    n_quo[j] = {w_quo_in[j][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[j] = w_trial[j][ROOT_W-1:0];
                    n_quo[j] = {w_quo_in[j][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            for (int j = 0; j < NCOMP; j++) begin
                r_rem[k][j] <= n_rem[j];
                r_quo[k][j] <= n_quo[j];
                r_lo[k][j]  <= w_lo_in[j];
            end
            r_den[k]  <= w_den_in;
            r_side[k] <= w_side_in;
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    for (genvar j = 0; j < NCOMP; j++) begin : g_out
        assign o_quo[j] = r_quo[DIV_STAGES-1][j];
    end

endmodule

### design/qftv_unitize.sv
// Scales a four-component integer vector to unit length in Q1.30.
`timescale 1ns / 1ps
module qftv_unitize
    import qftv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_ok,
    input  t_comp i_comp [NCOMP],
    output logic  o_valid,
    output logic  o_ok,
    output t_unit o_unit [NCOMP]
);

    // Stage 0: magnitudes and signs.
    logic [MAG_W-1:0] r0_mag [NCOMP];
    logic [NCOMP-1:0] r0_neg;
    logic             r0_ok;
    logic             r0_vld;
    // Stage 1: largest magnitude.
    logic [MAG_W-1:0] r1_mag [NCOMP];
    logic [MAG_W-1:0] r1_top;
    logic [NCOMP-1:0] r1_neg;
    logic             r1_ok;
    logic             r1_vld;
    // Stage 2: coarse leading-one search by byte.
    logic [MAG_W-1:0] r2_mag [NCOMP];
    logic [MAG_W-1:0] r2_top;
    logic [2:0]       r2_grp;
    logic [7:0]       r2_byte;
    logic             r2_any;
    logic [NCOMP-1:0] r2_neg;
    logic             r2_ok;
    logic             r2_vld;
    // Stage 3: exact bit length.
    logic [MAG_W-1:0]  r3_mag [NCOMP];
    logic [BLEN_W-1:0] r3_blen;
    logic              r3_is_one;
    logic [NCOMP-1:0]  r3_neg;
    logic              r3_ok;
    logic              r3_vld;
    // Stage 4: scaled magnitudes.
    logic [NRM_W-1:0] r4_nm [NCOMP];
    logic [NCOMP-1:0] r4_neg;
    logic             r4_ok;
    logic             r4_vld;
    // Stage 5: squares.
    logic [SQ_W-1:0]  r5_sq [NCOMP];
    logic [NRM_W-1:0] r5_nm [NCOMP];
    logic [NCOMP-1:0] r5_neg;
    logic             r5_ok;
    logic             r5_vld;
    // Stage 6: sum of squares.
    logic [SUM_W-1:0] r6_sum;
    logic [NRM_W-1:0] r6_nm [NCOMP];
    logic [NCOMP-1:0] r6_neg;
    logic             r6_ok;
    logic             r6_vld;

    t_comp             w_abs [NCOMP];
    logic [MAG_W-1:0]  w_top;
    logic [COMP_W-1:0] w_pad;
    logic [2:0]        w_grp;
    logic              w_any;
    logic              w_do_rsh;
    logic [BLEN_W-1:0] w_rsh;
    logic [BLEN_W-1:0] w_lsh;
    logic [COMP_W-1:0] w_half;
    logic [COMP_W-1:0] w_shift [NCOMP];
    logic [NRM_W-1:0]  w_nm [NCOMP];

    logic                   w_sq_valid;
    logic [ROOT_W-1:0]      w_root;
    logic [UNIT_SIDE_W-1:0] w_side_in;
    logic [UNIT_SIDE_W-1:0] w_side_out;
    logic [NUM_W-1:0]       w_num [NCOMP];
    logic [DIV_SIDE_W-1:0]  w_dside_in;
    logic                   w_div_valid;
    logic [QUO_W-1:0]       w_quo [NCOMP];
    logic [DIV_SIDE_W-1:0]  w_dside_out;
    logic [QUO_W-1:0]       w_cap [NCOMP];

    logic  r_vld;
    logic  r_ok;
    t_unit r_unit [NCOMP];

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            w_abs[i] = i_comp[i][COMP_W-1] ? -i_comp[i] : i_comp[i];
        end
    end

    always_comb begin
        w_top = r0_mag[0];
        for (int i = 1; i < NCOMP; i++) begin
            if (r0_mag[i] > w_top) begin
                w_top = r0_mag[i];
            end
        end
    end

    always_comb begin
        w_pad = {1'b0, r1_top};
        w_grp = 3'd0;
        w_any = 1'b0;
        for (int g = 0; g < 8; g++) begin
            if (|w_pad[g*8 +: 8]) begin
                w_grp = 3'(g);
                w_any = 1'b1;
            end
        end
    end

    // Large values are shifted down with rounding to at most 2^30; small ones are shifted up
    // until the largest reaches at least 2^29.
    always_comb begin
        w_do_rsh = (r3_blen > BLEN_W'(30)) && !r3_is_one;
        w_rsh    = r3_blen - BLEN_W'(30);
        w_lsh    = (r3_blen < BLEN_W'(30)) ? BLEN_W'(30) - r3_blen : '0;
        w_half   = COMP_W'(1) << (w_rsh - BLEN_W'(1));
        for (int i = 0; i < NCOMP; i++) begin
            if (w_do_rsh) begin
                w_shift[i] = ({1'b0, r3_mag[i]} + w_half) >> w_rsh;
            end else begin
                w_shift[i] = {1'b0, r3_mag[i]} << w_lsh;
            end
            w_nm[i] = w_shift[i][NRM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r0_vld <= i_valid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NCOMP; i++) begin
            r0_mag[i] <= w_abs[i][MAG_W-1:0];
            r0_neg[i] <= i_comp[i][COMP_W-1];
            r1_mag[i] <= r0_mag[i];
            r2_mag[i] <= r1_mag[i];
            r3_mag[i] <= r2_mag[i];
            r4_nm[i]  <= w_nm[i];
            r5_sq[i]  <= SQ_W'(r4_nm[i] * r4_nm[i]);
            r5_nm[i]  <= r4_nm[i];
            r6_nm[i]  <= r5_nm[i];
        end
        r0_ok     <= i_ok;
        r1_top    <= w_top;
        r1_neg    <= r0_neg;
        r1_ok     <= r0_ok;
        r2_top    <= r1_top;
        r2_grp    <= w_grp;
        r2_byte   <= w_pad[w_grp*8 +: 8];
        r2_any    <= w_any;
        r2_neg    <= r1_neg;
        r2_ok     <= r1_ok;
        r3_blen   <= r2_any ? {r2_grp, 3'b000} + BLEN_W'(f_bitlen8(r2_byte)) : '0;
        r3_is_one <= (r2_top == ONE_Q30_MAG);
        r3_neg    <= r2_neg;
        r3_ok     <= r2_ok && r2_any;
        r4_neg    <= r3_neg;
        r4_ok     <= r3_ok;
        r5_neg    <= r4_neg;
        r5_ok     <= r4_ok;
        r6_sum    <= SUM_W'(r5_sq[0]) + SUM_W'(r5_sq[1])
                   + SUM_W'(r5_sq[2]) + SUM_W'(r5_sq[3]);
        r6_neg    <= r5_neg;
        r6_ok     <= r5_ok;
    end

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            w_side_in[i*NRM_W +: NRM_W] = r6_nm[i];
        end
        w_side_in[NCOMP*NRM_W +: NCOMP] = r6_neg;
        w_side_in[UNIT_SIDE_W-1]        = r6_ok;
    end

    qftv_isqrt #(
        .SIDE_W (UNIT_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_sum   (r6_sum),
        .i_side  (w_side_in),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_side_out)
    );

    // Numerator carries the half-divisor so the quotient rounds half up.
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            w_num[i] = {w_side_out[i*NRM_W +: NRM_W], 30'd0} + NUM_W'(w_root >> 1);
        end
        w_dside_in = w_side_out[UNIT_SIDE_W-1 -: DIV_SIDE_W];
    end

    qftv_divider #(
        .SIDE_W (DIV_SIDE_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_num   (w_num),
        .i_den   (w_root),
        .i_side  (w_dside_in),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_side  (w_dside_out)
    );

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            w_cap[i] = (w_quo[i] > ONE_Q30_QUO) ? ONE_Q30_QUO : w_quo[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NCOMP; i++) begin
            r_unit[i] <= w_dside_out[i] ? -OUT_W'(w_cap[i]) : OUT_W'(w_cap[i]);
        end
        r_ok <= w_dside_out[DIV_SIDE_W-1];
    end

    assign o_valid = r_vld;
    assign o_ok    = r_ok;
    assign o_unit  = r_unit;

endmodule

### design/qftv_rotcore.sv
// Dot and cross products of the unit vectors and choice of the raw quaternion.
`timescale 1ns / 1ps
module qftv_rotcore
    import qftv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_ok,
    input  t_unit i_f [3],
    input  t_unit i_t [3],
    output logic  o_valid,
    output logic  o_ok,
    output t_comp o_comp [NCOMP]
);

    t_comp       w_p [9];
    t_unit       w_f1_abs;
    t_comp       w_round;
    t_comp       w_dot;
    logic        w_opp;

    t_comp       r1_p [9];
    t_unit       r1_f [3];
    logic        r1_hint;
    logic        r1_ok;
    logic        r1_vld;

    t_comp       r2_cross [3];
    t_comp       r2_dsum;
    t_unit       r2_f [3];
    logic        r2_hint;
    logic        r2_ok;
    logic        r2_vld;

    t_comp       r3_comp [NCOMP];
    logic        r3_ok;
    logic        r3_vld;

    assign w_p[0] = i_f[1] * i_t[2];
    assign w_p[1] = i_f[2] * i_t[1];
    assign w_p[2] = i_f[2] * i_t[0];
    assign w_p[3] = i_f[0] * i_t[2];
    assign w_p[4] = i_f[0] * i_t[1];
    assign w_p[5] = i_f[1] * i_t[0];
    assign w_p[6] = i_f[0] * i_t[0];
    assign w_p[7] = i_f[1] * i_t[1];
    assign w_p[8] = i_f[2] * i_t[2];

    assign w_f1_abs = i_f[1][OUT_W-1] ? -i_f[1] : i_f[1];

    // Rounding half up from Q2.60 is a floor of the biased value.
    always_comb begin
        w_round = (r2_dsum + HALF_Q30) >>> 30;
        if (w_round > ONE_Q30) begin
            w_dot = ONE_Q30;
        end else if (w_round < -ONE_Q30) begin
            w_dot = -ONE_Q30;
        end else begin
            w_dot = w_round;
        end
        w_opp = (w_dot < DOT_OPPOSITE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p    <= w_p;
        r1_f    <= i_f;
        r1_hint <= (w_f1_abs < Y_HINT_LIMIT);
        r1_ok   <= i_ok;

        r2_cross[0] <= r1_p[0] - r1_p[1];
        r2_cross[1] <= r1_p[2] - r1_p[3];
        r2_cross[2] <= r1_p[4] - r1_p[5];
        r2_dsum     <= r1_p[6] + r1_p[7] + r1_p[8];
        r2_f        <= r1_f;
        r2_hint     <= r1_hint;
        r2_ok       <= r1_ok;

        // Nearly opposite vectors turn half a revolution about source x hint.
        if (w_opp) begin
            if (r2_hint) begin
                r3_comp[0] <= -COMP_W'(r2_f[2]);
                r3_comp[1] <= '0;
                r3_comp[2] <= COMP_W'(r2_f[0]);
            end else begin
                r3_comp[0] <= '0;
                r3_comp[1] <= COMP_W'(r2_f[2]);
                r3_comp[2] <= -COMP_W'(r2_f[1]);
            end
            r3_comp[3] <= '0;
        end else begin
            r3_comp[0] <= r2_cross[0];
            r3_comp[1] <= r2_cross[1];
            r3_comp[2] <= r2_cross[2];
            r3_comp[3] <= (ONE_Q30 + w_dot) <<< 30;
        end
        r3_ok <= r2_ok;
    end

    assign o_valid = r3_vld;
    assign o_ok    = r3_ok;
    assign o_comp  = r3_comp;

endmodule

### design/quaternion_from_two_vectors.sv
// Top level: shortest-arc rotation quaternion between two Q16.16 vectors.
//
// A transaction is taken on every clock edge with start high; busy never rises, so a new
// vector pair may follow in every cycle. Each result appears on the o_ ports for one cycle,
// marked by o_valid, in input order; the receiver cannot hold it off, so it must capture
// it then. The pipeline runs through two normalizers in series (71 registers each: seven
// scaling stages, a 32-stage square root, a 31-stage divider and an output register) plus
// a three-stage dot and cross product core. When o_ok is low the four quaternion
// components are zero.
`timescale 1ns / 1ps
module quaternion_from_two_vectors
    import qftv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] i_from_x,
    input  logic signed [31:0] i_from_y,
    input  logic signed [31:0] i_from_z,
    input  logic signed [31:0] i_to_x,
    input  logic signed [31:0] i_to_y,
    input  logic signed [31:0] i_to_z,
    output logic        o_valid,
    output logic signed [31:0] o_quat_x,
    output logic signed [31:0] o_quat_y,
    output logic signed [31:0] o_quat_z,
    output logic signed [31:0] o_quat_w,
    output logic        o_ok
);

    t_comp w_from [NCOMP];
    t_comp w_to   [NCOMP];
    t_unit w_fu   [NCOMP];
    t_unit w_tu   [NCOMP];
    t_unit w_qu   [NCOMP];
    t_unit w_f3   [3];
    t_unit w_t3   [3];
    t_comp w_raw  [NCOMP];
    logic  w_accept;
    logic  w_fvalid;
    logic  w_fok;
    logic  w_tvalid;
    logic  w_tok;
    logic  w_cvalid;
    logic  w_cok;
    logic  w_qok;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_from[0] = COMP_W'(i_from_x);
    assign w_from[1] = COMP_W'(i_from_y);
    assign w_from[2] = COMP_W'(i_from_z);
    assign w_from[3] = '0;
    assign w_to[0]   = COMP_W'(i_to_x);
    assign w_to[1]   = COMP_W'(i_to_y);
    assign w_to[2]   = COMP_W'(i_to_z);
    assign w_to[3]   = '0;

    qftv_unitize u_from_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_ok    (1'b1),
        .i_comp  (w_from),
        .o_valid (w_fvalid),
        .o_ok    (w_fok),
        .o_unit  (w_fu)
    );

    qftv_unitize u_to_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_ok    (1'b1),
        .i_comp  (w_to),
        .o_valid (w_tvalid),
        .o_ok    (w_tok),
        .o_unit  (w_tu)
    );

    assign w_f3[0] = w_fu[0];
    assign w_f3[1] = w_fu[1];
    assign w_f3[2] = w_fu[2];
    assign w_t3[0] = w_tu[0];
    assign w_t3[1] = w_tu[1];
    assign w_t3[2] = w_tu[2];

    qftv_rotcore u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fvalid && w_tvalid),
        .i_ok    (w_fok && w_tok),
        .i_f     (w_f3),
        .i_t     (w_t3),
        .o_valid (w_cvalid),
        .o_ok    (w_cok),
        .o_comp  (w_raw)
    );

    qftv_unitize u_quat_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cvalid),
        .i_ok    (w_cok),
        .i_comp  (w_raw),
        .o_valid (o_valid),
        .o_ok    (w_qok),
        .o_unit  (w_qu)
    );

    assign o_ok     = w_qok;
    assign o_quat_x = w_qok ? w_qu[0] : '0;
    assign o_quat_y = w_qok ? w_qu[1] : '0;
    assign o_quat_z = w_qok ? w_qu[2] : '0;
    assign o_quat_w = w_qok ? w_qu[3] : '0;

endmodule

### design/qftv_checker.sv
// Port-level checks for the quaternion block, bound to the top level.
`timescale 1ns / 1ps
module qftv_checker
    import qftv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic signed [31:0] o_quat_x,
    input logic signed [31:0] o_quat_y,
    input logic signed [31:0] o_quat_z,
    input logic signed [31:0] o_quat_w,
    input logic        o_ok
);

    // Every accepted transaction produces its result after the fixed latency.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_valid)
        else $error("result strobe missing after fixed latency");

    a_fail_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_quat_x == 0 && o_quat_y == 0
                                && o_quat_z == 0 && o_quat_w == 0))
        else $error("failed result carries nonzero components");

    // The scalar part, from one plus the dot, lies in [0, 1] in Q1.30; it is zero for a half turn.
    a_w_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_quat_w >= 0 && o_quat_w <= 32'sd1073741824))
        else $error("scalar component out of range");

    a_xyz_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_quat_x <= 32'sd1073741824 && o_quat_x >= -32'sd1073741824
                               && o_quat_y <= 32'sd1073741824
                               && o_quat_y >= -32'sd1073741824
                               && o_quat_z <= 32'sd1073741824
                               && o_quat_z >= -32'sd1073741824))
        else $error("vector component out of range");

endmodule

bind quaternion_from_two_vectors qftv_checker u_qftv_checker (.*);

### dv/tb_quaternion_from_two_vectors.sv
// Testbench for the shortest-arc quaternion block: self-checking, random and directed vectors.
`timescale 1ns / 1ps
module tb_quaternion_from_two_vectors;
    import qftv_pkg::*;

    localparam int ONE_Q  = 1073741824;
    localparam int HALF_Q = 536870912;
    localparam longint DOT_OPP  = -64'sd1073634449;
    localparam longint HINT_LIM = 64'sd966367642;
    localparam int WATCHDOG_LIMIT = 4 * TOTAL_LAT + 1000;

    typedef struct {
        logic signed [31:0] qx, qy, qz, qw;
        logic               ok;
    } t_rot;

    // Returns the magnitude of a signed 64-bit value.
    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s) bit_v >>= 2;
        while (bit_v != 0) begin
            if (s >= res + bit_v) begin
                s -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Scales n components to unit length in Q1.30; returns 0 if all are zero.
    function automatic bit to_unit(input longint c[4], input int n, output longint o[4]);
        longint unsigned m[4];
        longint unsigned top, sum, len, q;
        int r, l;
        top = 0; sum = 0; r = 0; l = 0;
        for (int i = 0; i < 4; i++) o[i] = 0;
        for (int i = 0; i < n; i++) begin
            m[i] = abs64(c[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) return 0;
        while ((top >> r) >= ONE_Q) r++;
        if (top > ONE_Q && r > 0) begin
            for (int i = 0; i < n; i++) m[i] = (m[i] + (64'd1 << (r - 1))) >> r;
        end else begin
            while ((top << l) < HALF_Q) l++;
            for (int i = 0; i < n; i++) m[i] <<= l;
        end
        for (int i = 0; i < n; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        if (len == 0) return 0;
        for (int i = 0; i < n; i++) begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            if (q > ONE_Q) q = ONE_Q;
            o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic t_rot shortest_arc(input logic signed [31:0] v[6]);
        longint fv[4], tv[4], f[4], t[4], ax[4], q[4];
        longint d, x;
        bit ok;
        t_rot res;
        for (int i = 0; i < 4; i++) begin
            fv[i] = 0; tv[i] = 0; q[i] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            fv[i] = v[i];
            tv[i] = v[i + 3];
        end
        ok = to_unit(fv, 3, f);
        if (ok) ok = to_unit(tv, 3, t);
        if (ok) begin
            x = f[0] * t[0] + f[1] * t[1] + f[2] * t[2] + HALF_Q;
            if (x >= 0) d = longint'(longint'(unsigned'(x)) >>> 30);
            else d = -longint'((longint'(unsigned'(-x)) + ONE_Q - 1) >> 30);
            if (d > ONE_Q) d = ONE_Q;
            if (d < -ONE_Q) d = -ONE_Q;
            if (d < DOT_OPP) begin
                // Nearly opposite: half turn about source cross hint axis.
                if (abs64(f[1]) < HINT_LIM) begin
                    ax[0] = -f[2]; ax[1] = 0; ax[2] = f[0];
                end else begin
                    ax[0] = 0; ax[1] = f[2]; ax[2] = -f[1];
                end
                ax[3] = 0;
                ok = to_unit(ax, 3, q);
                q[3] = 0;
            end else begin
                ax[0] = f[1] * t[2] - f[2] * t[1];
                ax[1] = f[2] * t[0] - f[0] * t[2];
                ax[2] = f[0] * t[1] - f[1] * t[0];
                ax[3] = (ONE_Q + d) << 30;
                ok = to_unit(ax, 4, q);
            end
        end
        res.ok = ok;
        res.qx = ok ? 32'(q[0]) : '0;
        res.qy = ok ? 32'(q[1]) : '0;
        res.qz = ok ? 32'(q[2]) : '0;
        res.qw = ok ? 32'(q[3]) : '0;
        return res;
    endfunction

    class rot_scoreboard;
        t_rot pending_rots[$];
        int   n_errors;
        int   n_checked;

        function void note_pair(input logic signed [31:0] v[6]);
            pending_rots.push_back(shortest_arc(v));
        endfunction

        function void check_rot(input t_rot got);
            t_rot want;
            if (pending_rots.size() == 0) begin
                $error("result with no transaction pending");
                n_errors++;
                return;
            end
            want = pending_rots.pop_front();
            n_checked++;
            if (got.qx !== want.qx) begin
                $error("quat_x expected %0d actual %0d", want.qx, got.qx); n_errors++;
            end
            if (got.qy !== want.qy) begin
                $error("quat_y expected %0d actual %0d", want.qy, got.qy); n_errors++;
            end
            if (got.qz !== want.qz) begin
                $error("quat_z expected %0d actual %0d", want.qz, got.qz); n_errors++;
            end
            if (got.qw !== want.qw) begin
                $error("quat_w expected %0d actual %0d", want.qw, got.qw); n_errors++;
            end
            if (got.ok !== want.ok) begin
                $error("ok expected %0d actual %0d", want.ok, got.ok); n_errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_from_x = '0, i_from_y = '0, i_from_z = '0;
    logic signed [31:0] i_to_x = '0, i_to_y = '0, i_to_z = '0;
    logic               o_valid;
    logic signed [31:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic               o_ok;

    rot_scoreboard sb = new();
    int idle_pct = 0;
    int n_sent = 0;
    int n_opposite = 0;
    int n_invalid = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    quaternion_from_two_vectors u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_from_x(i_from_x), .i_from_y(i_from_y), .i_from_z(i_from_z),
        .i_to_x(i_to_x), .i_to_y(i_to_y), .i_to_z(i_to_z),
        .o_valid(o_valid), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z), .o_quat_w(o_quat_w), .o_ok(o_ok)
    );

    // Results and accepted transactions are both sampled at the rising edge.
    always @(posedge i_clk) begin
        t_rot got;
        logic signed [31:0] v[6];
        if (i_rst_n && start && !busy) begin
            v = '{i_from_x, i_from_y, i_from_z, i_to_x, i_to_y, i_to_z};
            sb.note_pair(v);
        end
        if (i_rst_n && o_valid) begin
            got.qx = o_quat_x; got.qy = o_quat_y; got.qz = o_quat_z;
            got.qw = o_quat_w; got.ok = o_ok;
            sb.check_rot(got);
        end
        if ((i_rst_n && start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one pair, idling first at random, and holds start until accepted.
    task automatic send_pair(input logic signed [31:0] v[6]);
        t_rot want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_from_x <= v[0]; i_from_y <= v[1]; i_from_z <= v[2];
        i_to_x <= v[3]; i_to_y <= v[4]; i_to_z <= v[5];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_sent++;
        want = shortest_arc(v);
        if (want.ok == 1'b0) n_invalid++;
        else if (want.qw == 0) n_opposite++;
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(131072)) - 65536;
            2: return $signed($urandom_range(4096)) - 2048;
            3: return 32'sd0;
            4: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    task automatic random_pair();
        logic signed [31:0] v[6];
        int k;
        for (int i = 0; i < 6; i++) v[i] = rand_comp();
        case ($urandom_range(9))
            0, 1: begin
                // Target a negated, slightly perturbed source to reach the half-turn path.
                for (int i = 0; i < 3; i++) begin
                    k = $signed($urandom_range(6)) - 3;
                    v[i + 3] = -v[i] + k;
                end
            end
            2: begin
                // Target a scaled copy of the source: parallel vectors.
                k = $urandom_range(3);
                for (int i = 0; i < 3; i++) v[i + 3] = v[i] >>> k;
            end
            3: begin
                // Source close to the y axis selects the x hint axis.
                v[0] = $signed($urandom_range(20000)) - 10000;
                v[1] = $urandom_range(1) ? 32'sd65536 : -32'sd65536;
                v[2] = $signed($urandom_range(20000)) - 10000;
                for (int i = 0; i < 3; i++) v[i + 3] = -v[i];
            end
            default: ;
        endcase
        send_pair(v);
    endtask

    initial begin
        logic signed [31:0] v[6];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vectors, extremes, parallel, opposite on both hint axes.
        v = '{0, 0, 0, 65536, 0, 0};                            send_pair(v);
        v = '{65536, 0, 0, 0, 0, 0};                            send_pair(v);
        v = '{0, 0, 0, 0, 0, 0};                                send_pair(v);
        v = '{65536, 0, 0, 65536, 0, 0};                        send_pair(v);
        v = '{65536, 0, 0, -65536, 0, 0};                       send_pair(v);
        v = '{0, 65536, 0, 0, -65536, 0};                       send_pair(v);
        v = '{0, 0, 65536, 0, 0, -65536};                       send_pair(v);
        v = '{65536, 0, 0, 0, 65536, 0};                        send_pair(v);
        v = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh80000000, 32'sh80000000};     send_pair(v);
        v = '{32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0};        send_pair(v);
        v = '{1, 0, 0, 0, 0, 1};                                send_pair(v);
        v = '{1, 1, 1, -1, -1, -1};                             send_pair(v);
        v = '{-1, -1, -1, 32'sh80000000, 32'sh7FFFFFFF, 1};     send_pair(v);
        v = '{30000, 65536, 0, -30000, -65536, 0};              send_pair(v);
        v = '{65536, 65536, 65536, -65537, -65535, -65536};     send_pair(v);
        v = '{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F,
              32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0};     send_pair(v);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 27 : (phase == 1) ? 71 : 0;
            repeat (165) random_pair();
        end
        start <= 1'b0;

        while (sb.pending_rots.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);

        $display("Sent %0d vector pairs, %0d results checked.", n_sent, sb.n_checked);
        $display("Half turns: %0d, invalid inputs: %0d.", n_opposite, n_invalid);
        if (sb.n_errors == 0 && sb.pending_rots.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
